// ----- rtl/hpa_pkg.sv -----
// Shared types and constants for the handle pool allocator.
`timescale 1ns / 1ps

package hpa_pkg;

    localparam int CMD_W        = 2;
    localparam int COUNT_W      = 6;
    localparam int OUT_HANDLE_W = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FETCH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    localparam logic             REG_CAPACITY = 1'b0;
    localparam logic [COUNT_W-1:0] CAP_RESET  = 6'd30;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic cmp_en;
        logic rel_en;
        logic load_en;
    } used_ctrl_t;

    typedef struct packed {
        logic push;
        logic pop;
    } free_ctrl_t;

endpackage

// ----- rtl/hpa_used_cell.sv -----
// One entry of the in-use list: compare, close-the-gap shift and append.
`timescale 1ns / 1ps

module hpa_used_cell #(
    parameter int HANDLE_BITS = 16,
    parameter int CW          = 6,
    parameter int IDX         = 0
) (
    input  logic                   aclk,
    input  hpa_pkg::used_ctrl_t    ctrl,
    input  logic [CW-1:0]          used_fill,
    input  logic [HANDLE_BITS-1:0] cmp_handle,
    input  logic [HANDLE_BITS-1:0] load_handle,
    input  logic [HANDLE_BITS-1:0] next_entry,
    input  logic                   found_in,
    output logic [HANDLE_BITS-1:0] entry,
    output logic                   found_out
);
    import hpa_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [HANDLE_BITS-1:0] entry_reg;
    logic                   match_reg;
    logic                   valid;

    assign valid     = IDX_C < used_fill;
    assign entry     = entry_reg;
    assign found_out = found_in | match_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            match_reg <= valid && (entry_reg == cmp_handle);
        end
        if (ctrl.load_en && (used_fill == IDX_C)) begin
            entry_reg <= load_handle;
        end else if (ctrl.rel_en && found_out) begin
            entry_reg <= next_entry;
        end
    end

endmodule

// ----- rtl/hpa_free_cell.sv -----
// One entry of the free stack: shift down on push, up on pop.
`timescale 1ns / 1ps

module hpa_free_cell #(
    parameter int HANDLE_BITS = 16
) (
    input  logic                   aclk,
    input  hpa_pkg::free_ctrl_t    ctrl,
    input  logic [HANDLE_BITS-1:0] prev_entry,
    input  logic [HANDLE_BITS-1:0] next_entry,
    output logic [HANDLE_BITS-1:0] entry
);
    import hpa_pkg::*;

    logic [HANDLE_BITS-1:0] entry_reg;

    assign entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            entry_reg <= prev_entry;
        end else if (ctrl.pop) begin
            entry_reg <= next_entry;
        end
    end

endmodule

// ----- rtl/handle_pool_allocator.sv -----
// Handle pool allocator top level: free stack, in-use list, control and APB register.
//
// Usage: commands enter on the s_ channel (s_cmd: insert, fetch, release; s_handle),
// one result per command leaves on the m_ channel (m_ok, m_handle_out, m_free_count,
// m_used_count). Both channels use valid/ready.
// Timing: a command is accepted when s_valid and s_ready are both high; at that edge
// every in-use cell compares its entry with the handle. In the EXEC state the first
// match along the cell chain resolves; at commit both stacks update and the output
// register loads. m_valid rises at the commit edge, and no new command is accepted
// until the previous one has committed.
// The output register holds the result while the receiver stalls; a command
// that finishes while the previous result is still held waits in the EXEC state
// and s_ready stays low until its result is loaded. Reset clears both counts
// (pools empty) and sets capacity to 30. capacity sits at APB address 0; the user
// must write it only while the block is idle, as the block does not enforce this.
`timescale 1ns / 1ps

module handle_pool_allocator #(
    parameter int POOL_DEPTH  = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpa_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [hpa_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [hpa_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [hpa_pkg::CMD_W-1:0]           s_cmd,
    input  logic [HANDLE_BITS-1:0]              s_handle,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_ok,
    output logic [hpa_pkg::OUT_HANDLE_W-1:0]    m_handle_out,
    output logic [hpa_pkg::COUNT_W-1:0]         m_free_count,
    output logic [hpa_pkg::COUNT_W-1:0]         m_used_count
);
    import hpa_pkg::*;

    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int SW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;

    localparam logic [CW-1:0] DEPTH_C  = CW'(POOL_DEPTH);
    localparam logic [SW-1:0] DEPTH_SW = SW'(POOL_DEPTH);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]     capacity_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [CW-1:0]          free_top_reg, free_top_next;
    logic [CW-1:0]          used_fill_reg, used_fill_next;

    logic                     m_valid_reg;
    logic                     ok_reg;
    logic [OUT_HANDLE_W-1:0]  handle_out_reg;
    logic [COUNT_W-1:0]       free_count_reg;
    logic [COUNT_W-1:0]       used_count_reg;

    logic [HANDLE_BITS-1:0] free_entry [POOL_DEPTH];
    logic [HANDLE_BITS-1:0] used_entry [POOL_DEPTH];
    logic                   found      [POOL_DEPTH+1];

    logic            accept;
    logic            commit;
    logic            cfg_write;
    logic [SW-1:0]   total;
    logic            free_full;
    logic            used_full;
    logic            insert_ok;
    logic            fetch_ok;
    logic            release_ok;
    logic            op_ok;
    used_ctrl_t      used_ctrl;
    free_ctrl_t      free_ctrl;

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(capacity_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
            capacity_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Control
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    assign total     = SW'(used_fill_reg) + SW'(free_top_reg);
    assign free_full = (free_top_reg == DEPTH_C);
    assign used_full = (used_fill_reg == DEPTH_C);

    assign insert_ok  = (cmd_reg == CMD_INSERT) && (total < SW'(capacity_reg))
                        && (total < DEPTH_SW) && !free_full;
    assign fetch_ok   = (cmd_reg == CMD_FETCH) && (free_top_reg != '0) && !used_full;
    assign release_ok = (cmd_reg == CMD_RELEASE) && found[POOL_DEPTH] && !free_full;
    assign op_ok      = insert_ok || fetch_ok || release_ok;

    assign used_ctrl.cmp_en  = accept;
    assign used_ctrl.rel_en  = commit && release_ok;
    assign used_ctrl.load_en = commit && fetch_ok;
    assign free_ctrl.push    = commit && (insert_ok || release_ok);
    assign free_ctrl.pop     = commit && fetch_ok;

    always_comb begin
        free_top_next  = free_top_reg;
        used_fill_next = used_fill_reg;
        if (insert_ok) begin
            free_top_next = free_top_reg + 1'b1;
        end else if (fetch_ok) begin
            free_top_next  = free_top_reg - 1'b1;
            used_fill_next = used_fill_reg + 1'b1;
        end else if (release_ok) begin
            free_top_next  = free_top_reg + 1'b1;
            used_fill_next = used_fill_reg - 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            free_top_reg  <= '0;
            used_fill_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                free_top_reg  <= free_top_next;
                used_fill_reg <= used_fill_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_cmd;
            handle_reg <= s_handle;
        end
        if (commit) begin
            ok_reg         <= op_ok;
            handle_out_reg <= fetch_ok ? OUT_HANDLE_W'(free_entry[0]) : '0;
            free_count_reg <= COUNT_W'(free_top_next);
            used_count_reg <= COUNT_W'(used_fill_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = ok_reg;
    assign m_handle_out = handle_out_reg;
    assign m_free_count = free_count_reg;
    assign m_used_count = used_count_reg;

    // Cell chains
    assign found[0] = 1'b0;

    for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
        hpa_free_cell #(
            .HANDLE_BITS (HANDLE_BITS)
        ) u_free (
            .aclk       (aclk),
            .ctrl       (free_ctrl),
            .prev_entry ((i == 0) ? handle_reg : free_entry[(i == 0) ? 0 : i - 1]),
            .next_entry (free_entry[(i == POOL_DEPTH - 1) ? i : i + 1]),
            .entry      (free_entry[i])
        );

        hpa_used_cell #(
            .HANDLE_BITS (HANDLE_BITS),
            .CW          (CW),
            .IDX         (i)
        ) u_used (
            .aclk        (aclk),
            .ctrl        (used_ctrl),
            .used_fill   (used_fill_reg),
            .cmp_handle  (s_handle),
            .load_handle (free_entry[0]),
            .next_entry  (used_entry[(i == POOL_DEPTH - 1) ? i : i + 1]),
            .found_in    (found[i]),
            .entry       (used_entry[i]),
            .found_out   (found[i+1])
        );
    end

    // Checks
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total <= DEPTH_SW)
        else $error("free plus used count exceeds pool depth");

    a_fetch_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && fetch_ok |=> used_fill_reg == $past(used_fill_reg) + 1'b1)
        else $error("fetch did not grow used list");

    a_release_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && release_ok |=> free_top_reg == $past(free_top_reg) + 1'b1)
        else $error("release did not push onto free stack");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready && (state_reg == ST_EXEC))
        else $error("command accepted while another is in flight");

endmodule

// ----- tb/handle_pool_allocator_test.sv -----
// Self-checking testbench for the handle pool allocator: directed and random command traffic.
`timescale 1ns / 1ps

module handle_pool_allocator_test;
    import hpa_pkg::*;

    localparam int DEPTH = 32;
    localparam int HND_W = 16;
    localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;
    localparam int IDLE_PCT = 26;

    typedef struct packed {
        logic               ok;
        logic [HND_W-1:0]   hnd;
        logic [COUNT_W-1:0] nfree;
        logic [COUNT_W-1:0] nused;
    } pool_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd = CMD_INSERT;
    logic [HND_W-1:0]      s_handle = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_ok;
    logic [OUT_HANDLE_W-1:0] m_handle_out;
    logic [COUNT_W-1:0]    m_free_count;
    logic [COUNT_W-1:0]    m_used_count;

    pool_result_t       pending_results[$];
    logic [HND_W-1:0]   free_stack_model[$];
    logic [HND_W-1:0]   used_list_model[$];
    logic [COUNT_W-1:0] capacity_model = CAP_RESET;
    logic               steady = 1'b0;
    int                 err_cnt = 0;

    handle_pool_allocator #(
        .POOL_DEPTH  (DEPTH),
        .HANDLE_BITS (HND_W)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_handle     (s_handle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ok         (m_ok),
        .m_handle_out (m_handle_out),
        .m_free_count (m_free_count),
        .m_used_count (m_used_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("handle_pool_allocator_test: done, errors");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic int pool_limit();
        return (capacity_model > DEPTH) ? DEPTH : int'(capacity_model);
    endfunction

    function automatic void predict_pool(input logic [CMD_W-1:0] cmd,
                                         input logic [HND_W-1:0] hnd);
        pool_result_t r;
        int           idx;
        r = '0;
        idx = -1;
        case (cmd)
            CMD_INSERT: begin
                if (used_list_model.size() + free_stack_model.size() < pool_limit()
                        && free_stack_model.size() < DEPTH) begin
                    free_stack_model.insert(free_stack_model.size(), hnd);
                    r.ok = 1'b1;
                end
            end
            CMD_FETCH: begin
                if (free_stack_model.size() > 0 && used_list_model.size() < DEPTH) begin
                    r.hnd = free_stack_model[free_stack_model.size() - 1];
                    free_stack_model.delete(free_stack_model.size() - 1);
                    used_list_model.insert(used_list_model.size(), r.hnd);
                    r.ok = 1'b1;
                end
            end
            CMD_RELEASE: begin
                for (int i = 0; i < used_list_model.size(); i++)
                    if (idx < 0 && used_list_model[i] == hnd)
                        idx = i;
                if (idx >= 0 && free_stack_model.size() < DEPTH) begin
                    used_list_model.delete(idx);
                    free_stack_model.insert(free_stack_model.size(), hnd);
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.nfree = COUNT_W'(free_stack_model.size());
        r.nused = COUNT_W'(used_list_model.size());
        pending_results.insert(pending_results.size(), r);
    endfunction

    always @(posedge aclk) begin
        pool_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested transaction", 32'(m_handle_out), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_ok !== want.ok)
                    report_mismatch("ok", 32'(m_ok), 32'(want.ok));
                if (m_handle_out !== want.hnd)
                    report_mismatch("handle_out", 32'(m_handle_out), 32'(want.hnd));
                if (m_free_count !== want.nfree)
                    report_mismatch("free_count", 32'(m_free_count), 32'(want.nfree));
                if (m_used_count !== want.nused)
                    report_mismatch("used_count", 32'(m_used_count), 32'(want.nused));
            end
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [HND_W-1:0] hnd);
        @(negedge aclk);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_handle <= hnd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pool(cmd, hnd);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_model = value;
    endtask

    task automatic test_empty_pool();
        send_cmd(CMD_FETCH, 16'h0000);
        send_cmd(CMD_RELEASE, 16'h1234);
        send_cmd(CMD_UNDEFINED, 16'hFFFF);
    endtask

    task automatic test_capacity_limits();
        write_capacity(6'd0);
        send_cmd(CMD_INSERT, 16'h0001);
        write_capacity(6'd2);
        send_cmd(CMD_INSERT, 16'h0000);
        send_cmd(CMD_INSERT, 16'hFFFF);
        send_cmd(CMD_INSERT, 16'h8001);
        write_capacity(6'd1);
        send_cmd(CMD_INSERT, 16'h7FFE);
        send_cmd(CMD_FETCH, 16'hFFFF);
        send_cmd(CMD_FETCH, 16'h0000);
        send_cmd(CMD_FETCH, 16'h0000);
    endtask

    task automatic test_release_order();
        write_capacity(6'd63);
        send_cmd(CMD_INSERT, 16'h0007);
        send_cmd(CMD_INSERT, 16'h0007);
        send_cmd(CMD_INSERT, 16'hAAAA);
        send_cmd(CMD_INSERT, 16'h5555);
        repeat (4) send_cmd(CMD_FETCH, 16'h0000);
        send_cmd(CMD_RELEASE, 16'h0007);
        send_cmd(CMD_RELEASE, 16'hAAAA);
        send_cmd(CMD_RELEASE, 16'hBEEF);
        send_cmd(CMD_RELEASE, 16'h0007);
        send_cmd(CMD_RELEASE, 16'h0007);
    endtask

    task automatic run_traffic(input int count, input int insert_pct);
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [HND_W-1:0] hnd;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            hnd  = HND_W'($urandom);
            if (pick < 3) begin
                cmd = CMD_UNDEFINED;
            end else if (pick < 3 + insert_pct) begin
                cmd = CMD_INSERT;
                if ($urandom_range(99) < 30)
                    hnd = HND_W'($urandom_range(7));
            end else if (pick < 3 + insert_pct + (97 - insert_pct) / 2) begin
                cmd = CMD_FETCH;
            end else begin
                cmd = CMD_RELEASE;
                if (used_list_model.size() > 0 && $urandom_range(99) < 75)
                    hnd = used_list_model[$urandom_range(used_list_model.size() - 1)];
            end
            send_cmd(cmd, hnd);
        end
    endtask

    task automatic test_random_traffic();
        write_capacity(6'd32);
        run_traffic(150, 45);
        wait_drained();
        run_traffic(150, 30);
        write_capacity(6'd5);
        run_traffic(200, 35);
        write_capacity(6'd20);
        steady = 1'b1;
        run_traffic(150, 40);
        steady = 1'b0;
        write_capacity(COUNT_W'($urandom_range(0, 32)));
        run_traffic(150, 35);
        write_capacity(6'd3);
        run_traffic(100, 20);
        write_capacity(6'd32);
        run_traffic(100, 25);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_pool();
        test_capacity_limits();
        test_release_order();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge aclk);
        if (err_cnt == 0)
            $display("handle_pool_allocator_test: done, clean");
        else
            $display("handle_pool_allocator_test: done, errors");
        $finish;
    end

endmodule
